// ----- rtl/twa_pkg.sv -----
package twa_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 20;
    // 35 bits cover |x|,|y| <= 2^31 times the CORDIC gain and the sqrt(2) length
    localparam int XY_W         = 35;
    localparam int ACC_W        = 27;
    localparam int PERCENT_FULL = 100;
    localparam int ANGLE_MAX    = 180;

    localparam logic [1:0] CFG_ALERT_ANGLE    = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD_PCT  = 2'd1;
    localparam logic [1:0] CFG_BLINK_INTERVAL = 2'd2;

    localparam logic [7:0]  ALERT_ANGLE_RST    = 8'd20;
    localparam logic [6:0]  THRESHOLD_PCT_RST  = 7'd50;
    localparam logic [15:0] BLINK_INTERVAL_RST = 16'd500;

    // atan(2^-i) in degrees, 16 fraction bits
    localparam int ATAN_DEG_TAB [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_z;
        logic [31:0]        time_ms;
    } t_twa_req;

    typedef struct packed {
        logic       led_level;
        logic       tilt_active;
        logic [7:0] angle_degrees;
    } t_twa_rsp;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ACC_W-1:0] acc;
    } t_cordic_vec;

    // fields that ride along the CORDIC chain untouched
    typedef struct packed {
        logic [31:0] time_ms;
        logic        special;
        logic [7:0]  special_angle;
        logic        turned;
    } t_twa_side;

endpackage

// ----- rtl/twa_cordic_cell.sv -----
module twa_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  twa_pkg::t_cordic_vec i_vec,
    input  twa_pkg::t_twa_side  i_side,
    output logic                o_valid,
    output twa_pkg::t_cordic_vec o_vec,
    output twa_pkg::t_twa_side  o_side
);

    localparam logic signed [twa_pkg::ACC_W-1:0] ANGLE_STEP =
        twa_pkg::ACC_W'(twa_pkg::ATAN_DEG_TAB[STEP]);

    logic signed [twa_pkg::XY_W-1:0]  x_in;
    logic signed [twa_pkg::XY_W-1:0]  y_in;
    logic signed [twa_pkg::XY_W-1:0]  dx;
    logic signed [twa_pkg::XY_W-1:0]  dy;
    logic signed [twa_pkg::ACC_W-1:0] acc_in;

    logic                 r_valid;
    twa_pkg::t_cordic_vec r_vec;
    twa_pkg::t_cordic_vec n_vec;
    twa_pkg::t_twa_side   r_side;

    assign x_in   = i_vec.x;
    assign y_in   = i_vec.y;
    assign acc_in = i_vec.acc;
    assign dx     = y_in >>> STEP;
    assign dy     = x_in >>> STEP;

    // rotate toward the x axis; sign of y picks the direction
    always_comb begin
        if (!y_in[twa_pkg::XY_W-1]) begin
            n_vec.x   = x_in + dx;
            n_vec.y   = y_in - dy;
            n_vec.acc = acc_in + ANGLE_STEP;
        end else begin
            n_vec.x   = x_in - dx;
            n_vec.y   = y_in + dy;
            n_vec.acc = acc_in - ANGLE_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec  <= n_vec;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_side  = r_side;

endmodule

// ----- rtl/twa_angle_pipe.sv -----
module twa_angle_pipe (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  twa_pkg::t_twa_req i_req,
    input  logic [7:0]        i_alert_angle,
    output logic              o_valid,
    output logic [7:0]        o_angle,
    output logic              o_hit,
    output logic [31:0]       o_time_ms
);

    localparam int STEPS   = twa_pkg::CORDIC_STEPS;
    localparam int TOTAL_W = twa_pkg::ACC_W + 1;
    localparam int WHOLE_W = twa_pkg::ACC_W - twa_pkg::FRAC_BITS;

    localparam logic [7:0] ANGLE_ZERO     = 8'd0;
    localparam logic [7:0] ANGLE_DIAG     = 8'd45;
    localparam logic [7:0] ANGLE_RIGHT    = 8'd90;
    localparam logic [7:0] ANGLE_DIAG_BK  = 8'd135;
    localparam logic [7:0] ANGLE_STRAIGHT = 8'(twa_pkg::ANGLE_MAX);
    localparam logic signed [TOTAL_W-1:0] BASE_TURN =
        TOTAL_W'(90 * (2 ** twa_pkg::FRAC_BITS));

    logic signed [17:0]   x_s;
    logic signed [17:0]   z_s;
    logic signed [17:0]   y_abs;
    logic signed [17:0]   x_t;
    logic signed [17:0]   y_t;
    twa_pkg::t_cordic_vec n_vec0;
    twa_pkg::t_twa_side   n_side0;

    logic                 r_valid0;
    twa_pkg::t_cordic_vec r_vec0;
    twa_pkg::t_twa_side   r_side0;

    logic                 c_valid [0:STEPS];
    twa_pkg::t_cordic_vec c_vec   [0:STEPS];
    twa_pkg::t_twa_side   c_side  [0:STEPS];

    logic signed [TOTAL_W-1:0] total;
    logic signed [TOTAL_W-1:0] acc_ext;
    logic [WHOLE_W-1:0]        whole;
    logic [7:0]                n_angle;

    logic        r_fin_valid;
    logic [7:0]  r_fin_angle;
    logic        r_fin_hit;
    logic [31:0] r_fin_time;

    // fold into the right half plane and catch the cases the iteration cannot resolve
    always_comb begin
        x_s   = 18'(i_req.accel_x);
        z_s   = 18'(i_req.accel_z);
        y_abs = z_s[17] ? -z_s : z_s;
        x_t   = x_s[17] ? y_abs : x_s;
        y_t   = x_s[17] ? -x_s : y_abs;

        n_side0.time_ms       = i_req.time_ms;
        n_side0.turned        = x_s[17];
        n_side0.special       = 1'b1;
        n_side0.special_angle = ANGLE_ZERO;
        priority if (y_abs == 18'sd0) begin
            n_side0.special_angle = x_s[17] ? ANGLE_STRAIGHT : ANGLE_ZERO;
        end else if (x_s == 18'sd0) begin
            n_side0.special_angle = ANGLE_RIGHT;
        end else if (x_t == y_t) begin
            n_side0.special_angle = x_s[17] ? ANGLE_DIAG_BK : ANGLE_DIAG;
        end else begin
            n_side0.special = 1'b0;
        end

        n_vec0.x   = twa_pkg::XY_W'(x_t) <<< twa_pkg::FRAC_BITS;
        n_vec0.y   = twa_pkg::XY_W'(y_t) <<< twa_pkg::FRAC_BITS;
        n_vec0.acc = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (i_en) begin
            r_valid0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec0  <= n_vec0;
            r_side0 <= n_side0;
        end
    end

    assign c_valid[0] = r_valid0;
    assign c_vec[0]   = r_vec0;
    assign c_side[0]  = r_side0;

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        twa_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[g]),
            .i_vec   (c_vec[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_vec   (c_vec[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // add quadrant base, clamp to 0..180, drop fraction; specials keep their angle
    always_comb begin
        acc_ext = TOTAL_W'(c_vec[STEPS].acc);
        total   = (c_side[STEPS].turned ? BASE_TURN : '0) + acc_ext;
        whole   = total[twa_pkg::ACC_W-1:twa_pkg::FRAC_BITS];
        if (c_side[STEPS].special) begin
            n_angle = c_side[STEPS].special_angle;
        end else if (total[TOTAL_W-1]) begin
            n_angle = ANGLE_ZERO;
        end else if (whole > WHOLE_W'(twa_pkg::ANGLE_MAX)) begin
            n_angle = ANGLE_STRAIGHT;
        end else begin
            n_angle = whole[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (i_en) begin
            r_fin_valid <= c_valid[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin_angle <= n_angle;
            r_fin_hit   <= (n_angle > i_alert_angle);
            r_fin_time  <= c_side[STEPS].time_ms;
        end
    end

    assign o_valid   = r_fin_valid;
    assign o_angle   = r_fin_angle;
    assign o_hit     = r_fin_hit;
    assign o_time_ms = r_fin_time;

endmodule

// ----- rtl/twa_alarm.sv -----
module twa_alarm #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [7:0]        i_angle,
    input  logic              i_hit,
    input  logic [31:0]       i_time_ms,
    input  logic [6:0]        i_threshold_pct,
    input  logic [15:0]       i_blink_interval,
    output twa_pkg::t_twa_rsp o_rsp
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int PW = $clog2(WINDOW_DEPTH * twa_pkg::PERCENT_FULL + 1);
    localparam logic [6:0] PCT_FULL = 7'(twa_pkg::PERCENT_FULL);

    // hits of the last WINDOW_DEPTH samples, newest at bit 0
    logic [WINDOW_DEPTH-1:0] r_hits;
    logic [WINDOW_DEPTH-1:0] n_hits;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_alarm;
    logic                    n_alarm;
    logic                    r_phase;
    logic                    n_phase;
    logic                    r_pin;
    logic                    n_pin;
    logic [31:0]             r_prev;

    logic [6:0]    pct_sat;
    logic [PW-1:0] thr_up;
    logic [PW-1:0] thr_dn;
    logic [PW-1:0] count_scaled;
    logic [31:0]   elapsed;

    always_comb begin
        n_hits  = {r_hits[WINDOW_DEPTH-2:0], i_hit};
        n_count = r_count - CW'(r_hits[WINDOW_DEPTH-1]) + CW'(i_hit);

        // count > floor(W*p/100) is the same as W*p < 100*count
        pct_sat      = (i_threshold_pct > PCT_FULL) ? PCT_FULL : i_threshold_pct;
        thr_up       = PW'(WINDOW_DEPTH) * PW'(pct_sat);
        thr_dn       = PW'(WINDOW_DEPTH) * PW'(PCT_FULL - pct_sat);
        count_scaled = PW'(n_count) * PW'(twa_pkg::PERCENT_FULL);
        n_alarm      = r_alarm ? (thr_dn < count_scaled) : (thr_up < count_scaled);

        elapsed = i_time_ms - r_prev;
        n_phase = r_phase;
        n_pin   = r_pin;
        if (n_alarm) begin
            if (elapsed >= 32'(i_blink_interval)) begin
                n_pin   = ~r_phase;
                n_phase = ~r_phase;
            end
        end else begin
            n_pin = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits  <= '0;
            r_count <= '0;
            r_alarm <= 1'b0;
            r_phase <= 1'b0;
            r_pin   <= 1'b0;
            r_prev  <= '0;
        end else if (i_en && i_valid) begin
            r_hits  <= n_hits;
            r_count <= n_count;
            r_alarm <= n_alarm;
            r_phase <= n_phase;
            r_pin   <= n_pin;
            r_prev  <= i_time_ms;
        end
    end

    assign o_rsp.led_level     = n_pin;
    assign o_rsp.tilt_active   = n_alarm;
    assign o_rsp.angle_degrees = i_angle;

endmodule

// ----- rtl/tilt_window_alarm_core.sv -----
// Tilt window alarm.
// Input channel: i_in_valid / o_in_stall carry one request of X and Z
// acceleration and a millisecond time stamp. Output channel: o_out_valid /
// i_out_stall carry one response per request: LED level, tilt flag and the
// truncated |atan2(z,x)| angle in degrees. A transfer happens on a rising
// edge with valid high and stall low.
// Stages: one fold stage, 20 CORDIC cells (one iteration each), one
// clamp/compare stage and the output register, where window, hysteresis and
// LED state update. Throughput is one request per cycle unless the receiver
// stalls; the CORDIC chain is fully pipelined. When the receiver stalls a
// held response, the whole chain freezes and a one-entry skid buffer takes
// the request in flight; o_in_stall is a register output. A stalled response
// holds its value. Configuration is written through i_cfg_we / i_cfg_idx /
// i_cfg_data, by the user only while no request is in flight; the block
// does not enforce it. Reset (i_rst_n low, synchronous) empties the chain,
// clears the hit window and alarm state and loads the default registers.
module tilt_window_alarm_core #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  twa_pkg::t_twa_req i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output twa_pkg::t_twa_rsp o_out_rsp,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data
);

    logic [7:0]  r_alert_angle;
    logic [6:0]  r_threshold_pct;
    logic [15:0] r_blink_interval;

    logic              r_skid_valid;
    twa_pkg::t_twa_req r_skid;
    logic              r_out_valid;
    twa_pkg::t_twa_rsp r_out;

    logic              en;
    logic              ent_valid;
    twa_pkg::t_twa_req ent_req;

    logic              fin_valid;
    logic [7:0]        fin_angle;
    logic              fin_hit;
    logic [31:0]       fin_time;
    twa_pkg::t_twa_rsp rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alert_angle    <= twa_pkg::ALERT_ANGLE_RST;
            r_threshold_pct  <= twa_pkg::THRESHOLD_PCT_RST;
            r_blink_interval <= twa_pkg::BLINK_INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                twa_pkg::CFG_ALERT_ANGLE:    r_alert_angle    <= i_cfg_data[7:0];
                twa_pkg::CFG_THRESHOLD_PCT:  r_threshold_pct  <= i_cfg_data[6:0];
                twa_pkg::CFG_BLINK_INTERVAL: r_blink_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance the whole chain unless a response is held by the receiver
    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign ent_valid  = r_skid_valid || i_in_valid;
    assign ent_req    = r_skid_valid ? r_skid : i_in_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (en) begin
            r_skid_valid <= 1'b0;
        end else if (i_in_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && !r_skid_valid) begin
            r_skid <= i_in_req;
        end
    end

    twa_angle_pipe u_angle (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (ent_valid),
        .i_req         (ent_req),
        .i_alert_angle (r_alert_angle),
        .o_valid       (fin_valid),
        .o_angle       (fin_angle),
        .o_hit         (fin_hit),
        .o_time_ms     (fin_time)
    );

    twa_alarm #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_alarm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (fin_valid),
        .i_angle          (fin_angle),
        .i_hit            (fin_hit),
        .i_time_ms        (fin_time),
        .i_threshold_pct  (r_threshold_pct),
        .i_blink_interval (r_blink_interval),
        .o_rsp            (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule
